// ----- hw/rtl/bfcc_pkg.sv -----
// Package for the box frustum corner cull block.
// Holds the field widths, plane layout and the types shared by every module.
`timescale 1ns / 1ps

package bfcc_pkg;

    localparam int FIELD_W     = 16;
    localparam int COORD_W     = 16;
    localparam int COEF_W      = 16;
    localparam int PROD_W      = COORD_W + COEF_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int D_SHIFT     = 14;
    localparam int NUM_PLANES  = 6;
    localparam int NUM_CORNERS = 8;
    localparam int CORNER_W    = 3;
    localparam int COUNT_W     = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int PLANE_W     = 64;
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 8;

    localparam int A_POS = 0;
    localparam int B_POS = 16;
    localparam int C_POS = 32;
    localparam int D_POS = 48;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [COEF_W-1:0]  t_coef;
    typedef logic signed [PROD_W-1:0]  t_prod_val;
    typedef logic [NUM_PLANES-1:0][PLANE_W-1:0] t_planes;

    typedef struct packed {
        t_coord              lo_x;
        t_coord              lo_y;
        t_coord              lo_z;
        t_coord              hi_x;
        t_coord              hi_y;
        t_coord              hi_z;
        logic [CORNER_W-1:0] hint;
    } t_box;

    typedef struct packed {
        t_prod_val ax_lo;
        t_prod_val ax_hi;
        t_prod_val by_lo;
        t_prod_val by_hi;
        t_prod_val cz_lo;
        t_prod_val cz_hi;
    } t_prod;

    typedef t_prod [NUM_PLANES-1:0] t_prods;

    typedef struct packed {
        logic [COUNT_W-1:0]  tested;
        logic [CORNER_W-1:0] found;
        logic                visible;
    } t_result;

endpackage

// ----- hw/rtl/bfcc_cfg.sv -----
// Plane coefficient registers of the box frustum corner cull block.
// Written through the configuration channel; uses bfcc_pkg.
`timescale 1ns / 1ps

module bfcc_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [bfcc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bfcc_pkg::PLANE_W-1:0]  i_cfg_data,
    output bfcc_pkg::t_planes             o_planes
);
    import bfcc_pkg::*;

    t_planes r_plane;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
        end else if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(NUM_PLANES))) begin
            r_plane[i_cfg_index] <= i_cfg_data;
        end
    end

    assign o_planes = r_plane;

endmodule

// ----- hw/rtl/bfcc_mul.sv -----
// Product stage: the A, B and C coefficients of every plane times both box extents on their axes.
// Products are registered; uses bfcc_pkg.
`timescale 1ns / 1ps

module bfcc_mul (
    input  logic              i_clk,
    input  logic              i_en,
    input  bfcc_pkg::t_box    i_box,
    input  bfcc_pkg::t_planes i_planes,
    output bfcc_pkg::t_prods  o_prods
);
    import bfcc_pkg::*;

    t_prods r_prods;
    t_prods n_prods;

    always_comb begin
        t_coef a;
        t_coef b;
        t_coef c;
        for (int p = 0; p < NUM_PLANES; p++) begin
            a = t_coef'(i_planes[p][A_POS +: COEF_W]);
            b = t_coef'(i_planes[p][B_POS +: COEF_W]);
            c = t_coef'(i_planes[p][C_POS +: COEF_W]);
            n_prods[p].ax_lo = t_prod_val'(a) * t_prod_val'(i_box.lo_x);
            n_prods[p].ax_hi = t_prod_val'(a) * t_prod_val'(i_box.hi_x);
            n_prods[p].by_lo = t_prod_val'(b) * t_prod_val'(i_box.lo_y);
            n_prods[p].by_hi = t_prod_val'(b) * t_prod_val'(i_box.hi_y);
            n_prods[p].cz_lo = t_prod_val'(c) * t_prod_val'(i_box.lo_z);
            n_prods[p].cz_hi = t_prod_val'(c) * t_prod_val'(i_box.hi_z);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prods <= n_prods;
        end
    end

    assign o_prods = r_prods;

endmodule

// ----- hw/rtl/bfcc_eval.sv -----
// Plane sums for all eight corners and the hint-first corner selection.
// Combinational; fed by the product register; uses bfcc_pkg.
`timescale 1ns / 1ps

module bfcc_eval (
    input  bfcc_pkg::t_prods              i_prods,
    input  bfcc_pkg::t_planes             i_planes,
    input  logic [bfcc_pkg::CORNER_W-1:0] i_hint,
    output bfcc_pkg::t_result             o_result
);
    import bfcc_pkg::*;

    logic [NUM_CORNERS-1:0] corner_in;

    always_comb begin
        logic [NUM_PLANES-1:0] nonneg;
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] d_term;
        logic [COEF_W-1:0] d;
        t_prod_val px;
        t_prod_val py;
        t_prod_val pz;
        for (int k = 0; k < NUM_CORNERS; k++) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                d      = i_planes[p][D_POS +: COEF_W];
                d_term = {{(SUM_W - COEF_W - D_SHIFT){d[COEF_W-1]}}, d, {D_SHIFT{1'b0}}};
                px     = k[0] ? i_prods[p].ax_hi : i_prods[p].ax_lo;
                py     = k[1] ? i_prods[p].by_hi : i_prods[p].by_lo;
                pz     = k[2] ? i_prods[p].cz_hi : i_prods[p].cz_lo;
                sum    = SUM_W'(px) + SUM_W'(py) + SUM_W'(pz) + d_term;
                nonneg[p] = !sum[SUM_W-1];
            end
            corner_in[k] = &nonneg;
        end
    end

    always_comb begin
        logic hit;
        hit              = 1'b0;
        o_result.visible = 1'b0;
        o_result.found   = i_hint;
        o_result.tested  = COUNT_W'(NUM_CORNERS);
        if (corner_in[i_hint]) begin
            o_result.visible = 1'b1;
            o_result.tested  = COUNT_W'(1);
        end else begin
            for (int i = 0; i < NUM_CORNERS; i++) begin
                if (!hit && (CORNER_W'(i) != i_hint) && corner_in[i]) begin
                    hit              = 1'b1;
                    o_result.visible = 1'b1;
                    o_result.found   = CORNER_W'(i);
                    o_result.tested  = (CORNER_W'(i) < i_hint) ? COUNT_W'(i + 2)
                                                                : COUNT_W'(i + 1);
                end
            end
        end
    end

endmodule

// ----- hw/rtl/box_frustum_corner_cull.sv -----
// Box frustum corner cull: three-stage pipeline (input, products, result).
// An accepted request is held in the input register, then in the product and result registers.
// Throughput is one box per cycle while the output does not stall; empty stages close up while it stalls.
// Reset is synchronous, active low; it empties the pipeline and clears all planes,
// so after reset every box is visible on its hint corner with one corner tested.
`timescale 1ns / 1ps

module box_frustum_corner_cull (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // min_x, min_y, min_z, max_x, max_y, max_z (16 each), hint_corner (3), zero pad
    input  logic [bfcc_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // visible (1), found_corner (3), corners_tested (4)
    output logic [bfcc_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bfcc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bfcc_pkg::PLANE_W-1:0]     i_cfg_data
);
    import bfcc_pkg::*;

    t_planes planes;
    t_box    r_box;
    t_box    n_box;
    t_prods  prods;
    t_result n_res;
    t_result r_res;
    logic [CORNER_W-1:0] r_hint2;
    logic r_v1;
    logic r_v2;
    logic r_vo;
    logic en_o;
    logic en_2;
    logic en_1;

    assign o_cfg_ready = 1'b1;

    bfcc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_planes    (planes)
    );

    assign en_o       = !r_vo || i_m_tready;
    assign en_2       = !r_v2 || en_o;
    assign en_1       = !r_v1 || en_2;
    assign o_s_tready = en_1;

    always_comb begin
        n_box.lo_x = t_coord'(i_s_tdata[0*FIELD_W +: COORD_W]);
        n_box.lo_y = t_coord'(i_s_tdata[1*FIELD_W +: COORD_W]);
        n_box.lo_z = t_coord'(i_s_tdata[2*FIELD_W +: COORD_W]);
        n_box.hi_x = t_coord'(i_s_tdata[3*FIELD_W +: COORD_W]);
        n_box.hi_y = t_coord'(i_s_tdata[4*FIELD_W +: COORD_W]);
        n_box.hi_z = t_coord'(i_s_tdata[5*FIELD_W +: COORD_W]);
        n_box.hint = i_s_tdata[6*FIELD_W +: CORNER_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en_1) begin
                r_v1 <= i_s_tvalid;
            end
            if (en_2) begin
                r_v2 <= r_v1;
            end
            if (en_o) begin
                r_vo <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_1 && i_s_tvalid) begin
            r_box <= n_box;
        end
        if (en_2 && r_v1) begin
            r_hint2 <= r_box.hint;
        end
        if (en_o && r_v2) begin
            r_res <= n_res;
        end
    end

    bfcc_mul u_mul (
        .i_clk    (i_clk),
        .i_en     (en_2 && r_v1),
        .i_box    (r_box),
        .i_planes (planes),
        .o_prods  (prods)
    );

    bfcc_eval u_eval (
        .i_prods  (prods),
        .i_planes (planes),
        .i_hint   (r_hint2),
        .o_result (n_res)
    );

    assign o_m_tvalid = r_vo;
    assign o_m_tdata  = r_res;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_v1 && r_v2 && r_vo))
        else $error("input stalled while the pipeline has an empty stage");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo |-> ((r_res.tested != '0) && (r_res.tested <= COUNT_W'(NUM_CORNERS))))
        else $error("corners tested out of range");

    a_miss_tests_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vo && !r_res.visible) |-> (r_res.tested == COUNT_W'(NUM_CORNERS)))
        else $error("box culled before every corner was tested");
`endif

endmodule

// ----- tb/sv/box_frustum_corner_cull_tb.sv -----
// Self-checking testbench for box_frustum_corner_cull: streams boxes through the block
// and compares each cull result with a corner-by-corner plane test done in the bench.
// Depends on bfcc_pkg and the box_frustum_corner_cull top level.
`timescale 1ns / 1ps

module box_frustum_corner_cull_tb;
    import bfcc_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int NUM_PHASES   = 14;
    localparam int PHASE_BOXES  = 125;
    localparam int REG_PLANE_0  = 0;
    localparam int REG_SPARE_LO = 6;
    localparam int REG_SPARE_HI = 7;

    typedef enum {
        PL_ZERO, PL_NEG_FULL, PL_POS_FULL, PL_ONES, PL_RANDOM, PL_SLAB, PL_SLAB_EXACT
    } plane_mode_e;

    class cull_result_board;
        logic [PLANE_W-1:0] planes [NUM_PLANES];
        t_result expected_results [$];
        int errors;

        function new();
            foreach (planes[p]) planes[p] = '0;
            errors = 0;
        endfunction

        function void set_plane(int idx, logic [PLANE_W-1:0] value);
            if (idx >= REG_PLANE_0 && idx < REG_PLANE_0 + NUM_PLANES) begin
                planes[idx - REG_PLANE_0] = value;
            end
        endfunction

        function bit corner_passes(t_box bx, int corner);
            longint x, y, z, ca, cb, cc, cd, s;
            x = corner[0] ? bx.hi_x : bx.lo_x;
            y = corner[1] ? bx.hi_y : bx.lo_y;
            z = corner[2] ? bx.hi_z : bx.lo_z;
            for (int p = 0; p < NUM_PLANES; p++) begin
                ca = $signed(planes[p][A_POS +: COEF_W]);
                cb = $signed(planes[p][B_POS +: COEF_W]);
                cc = $signed(planes[p][C_POS +: COEF_W]);
                cd = $signed(planes[p][D_POS +: COEF_W]);
                s = ca * x + cb * y + cc * z + (cd <<< D_SHIFT);
                if (s < 0) return 1'b0;
            end
            return 1'b1;
        endfunction

        function t_result cull_box(t_box bx);
            t_result r;
            r.visible = 1'b0;
            r.found   = bx.hint;
            r.tested  = 1;
            if (corner_passes(bx, bx.hint)) begin
                r.visible = 1'b1;
            end else begin
                for (int k = 0; k < NUM_CORNERS; k++) begin
                    if (k == bx.hint) continue;
                    r.tested++;
                    if (corner_passes(bx, k)) begin
                        r.visible = 1'b1;
                        r.found   = k[CORNER_W-1:0];
                        break;
                    end
                end
            end
            return r;
        endfunction

        function void note_box(t_box bx);
            expected_results.push_back(cull_box(bx));
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        task report(string msg);
            if (errors < 100) $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] data);
            t_result got;
            t_result want;
            got = data;
            if (expected_results.size() == 0) begin
                report($sformatf("result 0x%02h with no request waiting", data));
            end else begin
                want = expected_results.pop_front();
                if (got.visible !== want.visible)
                    report($sformatf("visible got %0d want %0d", got.visible, want.visible));
                if (got.found !== want.found)
                    report($sformatf("found_corner got %0d want %0d", got.found, want.found));
                if (got.tested !== want.tested)
                    report($sformatf("corners_tested got %0d want %0d",
                                     got.tested, want.tested));
            end
        endtask
    endclass

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic [IN_TDATA_W-1:0]  i_s_tdata   = '0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b1;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [PLANE_W-1:0]     i_cfg_data  = '0;

    cull_result_board board;
    bit idle_en = 1'b0;
    int stall_left = 0;
    int slab_ctr [3] = '{0, 0, 0};
    int slab_half [3] = '{1000, 1000, 1000};

    box_frustum_corner_cull dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // The receiver deasserts ready at random, in bursts, while idle_en is set.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if (idle_en && $urandom_range(4) == 0) begin
            stall_left <= $urandom_range(2);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) board.check_result(o_m_tdata);
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("box_frustum_corner_cull_tb: FAIL");
        $finish;
    end

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic logic [PLANE_W-1:0] pack_plane(int a, int b, int c, int d);
        return {d[15:0], c[15:0], b[15:0], a[15:0]};
    endfunction

    function automatic t_box mk_box(int lx, int ly, int lz, int hx, int hy, int hz, int h);
        t_box bx;
        bx.lo_x = t_coord'(lx);
        bx.lo_y = t_coord'(ly);
        bx.lo_z = t_coord'(lz);
        bx.hi_x = t_coord'(hx);
        bx.hi_y = t_coord'(hy);
        bx.hi_z = t_coord'(hz);
        bx.hint = h[CORNER_W-1:0];
        return bx;
    endfunction

    function automatic int pick_gap();
        if (idle_en && $urandom_range(3) == 0) return $urandom_range(3, 1);
        return 0;
    endfunction

    function automatic int extreme_coord();
        case ($urandom_range(3))
            0: return -32768;
            1: return 32767;
            2: return 0;
            default: return -1;
        endcase
    endfunction

    function automatic t_box make_random_box();
        int lo [3];
        int hi [3];
        int sel;
        int tmp;
        sel = $urandom_range(9);
        for (int k = 0; k < 3; k++) begin
            if (sel <= 6) begin
                lo[k] = slab_ctr[k] + rand_between(-2 * slab_half[k], slab_half[k]);
                hi[k] = lo[k] + rand_between(0, 2 * slab_half[k]);
                if ($urandom_range(19) == 0) begin
                    tmp = lo[k];
                    lo[k] = hi[k];
                    hi[k] = tmp;
                end
            end else if (sel <= 8) begin
                lo[k] = int'($urandom());
                hi[k] = int'($urandom());
            end else begin
                lo[k] = extreme_coord();
                hi[k] = extreme_coord();
            end
        end
        return mk_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], $urandom_range(7));
    endfunction

    // The valid line is only lowered when a gap follows, so it never falls and rises
    // within the same step.
    task automatic send_box(input t_box bx, input int gap);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {bx.hint, bx.hi_z, bx.hi_y, bx.hi_x, bx.lo_z, bx.lo_y, bx.lo_x};
        do @(posedge i_clk); while (!o_s_tready);
        board.note_box(bx);
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic cfg_write(input int idx, input logic [PLANE_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx[CFG_IDX_W-1:0];
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_plane(idx, value);
    endtask

    task automatic program_planes(input plane_mode_e mode);
        logic [PLANE_W-1:0] vals [NUM_PLANES];
        int co [3];
        int main_c;
        int dd;
        int start;
        int idx;
        if (mode == PL_SLAB) begin
            for (int k = 0; k < 3; k++) begin
                slab_ctr[k]  = rand_between(-8000, 8000);
                slab_half[k] = rand_between(16, 4000);
            end
        end
        for (int p = 0; p < NUM_PLANES; p++) begin
            case (mode)
                PL_ZERO:     vals[p] = '0;
                PL_NEG_FULL: vals[p] = {4{16'h8000}};
                PL_POS_FULL: vals[p] = {4{16'h7FFF}};
                PL_ONES:     vals[p] = '1;
                PL_RANDOM:   vals[p] = {$urandom(), $urandom()};
                default: begin
                    // Two opposing planes per axis bound a slab around the centre.
                    for (int k = 0; k < 3; k++) begin
                        co[k] = (mode == PL_SLAB) ? rand_between(-800, 800) : 0;
                    end
                    main_c = 16384 + ((mode == PL_SLAB) ? rand_between(-1500, 1500) : 0);
                    if (p % 2 == 0) begin
                        co[p / 2] = main_c;
                        dd = -(slab_ctr[p / 2] - slab_half[p / 2]);
                    end else begin
                        co[p / 2] = -main_c;
                        dd = slab_ctr[p / 2] + slab_half[p / 2];
                    end
                    vals[p] = pack_plane(co[0], co[1], co[2], dd);
                end
            endcase
        end
        start = $urandom_range(NUM_PLANES - 1);
        for (int n = 0; n < NUM_PLANES; n++) begin
            idx = (start + n) % NUM_PLANES;
            cfg_write(REG_PLANE_0 + idx, vals[idx]);
        end
        if ($urandom_range(2) == 0) begin
            cfg_write($urandom_range(REG_SPARE_HI, REG_SPARE_LO), {$urandom(), $urandom()});
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        plane_mode_e mode;
        int v;
        board = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_en = 1'b1;

        // Planes still at reset: every box is visible on its hint corner.
        for (int k = 0; k < NUM_CORNERS; k++) begin
            v = k;
            send_box(mk_box(v[0] ? 32767 : -32768, v[1] ? 32767 : -32768,
                            v[2] ? 32767 : -32768, v[0] ? -32768 : 32767,
                            v[1] ? -32768 : 32767, v[2] ? -32768 : 32767, k), pick_gap());
        end
        wait_idle();

        // An exact cube of half width 1000 around the origin.
        for (int k = 0; k < 3; k++) begin
            slab_ctr[k]  = 0;
            slab_half[k] = 1000;
        end
        program_planes(PL_SLAB_EXACT);
        send_box(mk_box(-100, -100, -100, 100, 100, 100, 3), pick_gap());
        send_box(mk_box(2000, 2000, 2000, 3000, 3000, 3000, 0), pick_gap());
        send_box(mk_box(-3000, -3000, -3000, 500, 500, 500, 0), pick_gap());
        send_box(mk_box(500, 500, 500, -3000, -3000, -3000, 5), pick_gap());
        send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767, 2), pick_gap());
        send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767, 7), pick_gap());
        send_box(mk_box(-1000, -1000, -1000, 1000, 1000, 1000, 6), pick_gap());
        wait_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: mode = PL_NEG_FULL;
                1: mode = PL_POS_FULL;
                2: mode = PL_ONES;
                3: mode = PL_ZERO;
                4: mode = PL_RANDOM;
                default: begin
                    if ($urandom_range(5) == 0) mode = PL_RANDOM;
                    else mode = PL_SLAB;
                end
            endcase
            program_planes(mode);
            idle_en = (ph != NUM_PHASES - 1) && ($urandom_range(3) != 0);
            for (int n = 0; n < PHASE_BOXES; n++) begin
                send_box(make_random_box(), pick_gap());
            end
            wait_idle();
        end

        if (board.errors == 0) begin
            $display("box_frustum_corner_cull_tb: PASS");
        end else begin
            $display("box_frustum_corner_cull_tb: FAIL");
        end
        $finish;
    end
endmodule
